FILE: design/dwt97_lifting_line_filter_macros.svh
// Assertion macros for the 9/7 lifting line filter.
// Taken by `include in the files that carry concurrent assertions.
`ifndef DWT97_LIFTING_LINE_FILTER_MACROS_SVH
`define DWT97_LIFTING_LINE_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DWT97_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define DWT97_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dwt97_pkg.sv
// Shared types and constants of the 9/7 lifting line filter.
// No dependencies; the interfaces, controller, datapath, top level and testbench use it.
`timescale 1ns / 1ps

package dwt97_pkg;

	localparam int IO_W      = 24;
	localparam int COEF_W    = 18;
	localparam int FRAC      = 16;
	localparam int TAP_W     = 4;
	localparam int TAPS      = 9;
	localparam int EXTEND    = 4;
	localparam int LIFT_HI   = TAPS - 2;
	localparam int WIN_DEPTH = 12;
	localparam int WIN_IDX_W = 4;

	localparam logic [TAP_W-1:0] MID_TAP  = TAP_W'(EXTEND);
	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

	typedef logic signed [COEF_W-1:0] coef_t;

	// Q2.16 lifting and scaling coefficients
	localparam coef_t LIFT_ALPHA  = -18'sd103949;
	localparam coef_t LIFT_BETA   = -18'sd3472;
	localparam coef_t LIFT_GAMMA  = 18'sd57862;
	localparam coef_t LIFT_DELTA  = 18'sd29066;
	localparam coef_t SCALE_K     = 18'sd80621;
	localparam coef_t SCALE_INV_K = 18'sd53274;

	// operation phases of one multiply op
	localparam logic [1:0] PH_READ = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_WB   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ISCALE,
		ST_LIFT,
		ST_FSCALE,
		ST_EMIT,
		ST_SHORT,
		ST_CLEAR
	} ctrl_state_t;

	typedef struct packed {
		logic             win_shift;
		logic             win_clear;
		logic             load;
		logic             mul;
		logic             wb;
		logic             lift_op;
		logic             sub;
		logic             ended;
		logic [TAP_W-1:0] ra;
		logic [TAP_W-1:0] rb;
		logic [TAP_W-1:0] wt;
		coef_t            coef;
		logic             emit;
		logic             odd;
		logic             last;
		logic             err;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	function automatic coef_t lift_coef(input logic inv, input logic [1:0] step);
		coef_t c;
		case (step)
			2'd0: c = inv ? LIFT_DELTA : LIFT_ALPHA;
			2'd1: c = inv ? LIFT_GAMMA : LIFT_BETA;
			2'd2: c = inv ? LIFT_BETA  : LIFT_GAMMA;
			2'd3: c = inv ? LIFT_ALPHA : LIFT_DELTA;
			default: c = LIFT_ALPHA;
		endcase
		return c;
	endfunction

endpackage

FILE: design/dwt97_if.sv
// Channel interfaces of the 9/7 lifting line filter: samples, results, config.
// Depends on dwt97_pkg.
`timescale 1ns / 1ps

interface dwt97_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [dwt97_pkg::IO_W-1:0]   sample;
	logic                                line_end;
	modport source (output valid, sample, line_end, input ready);
	modport sink   (input valid, sample, line_end, output ready);
endinterface

interface dwt97_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [dwt97_pkg::IO_W-1:0]   coeff;
	logic                                odd_position;
	logic                                run_last;
	logic                                too_short;
	modport source (output valid, coeff, odd_position, run_last, too_short, input ready);
	modport sink   (input valid, coeff, odd_position, run_last, too_short, output ready);
endinterface

interface dwt97_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, direction, input ready);
	modport sink   (input valid, direction, output ready);
endinterface

FILE: design/dwt97_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dwt97_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: design/dwt97_datapath.sv
// Datapath: sample window, tap fetch with symmetric extension, partials RAM,
// shared multiplier with rounding and saturation, and the result register.
// Depends on dwt97_pkg and dwt97_ram.
`timescale 1ns / 1ps

module dwt97_datapath #(
	parameter int MAX_LINE    = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwt97_pkg::dp_cmd_t                 cmd,
	input  logic [$clog2(MAX_LINE)-1:0]        k,
	input  logic [$clog2(MAX_LINE)-1:0]        j,
	input  logic signed [dwt97_pkg::IO_W-1:0]  in_sample,
	output dwt97_pkg::dp_status_t              status,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dwt97_pkg::IO_W-1:0]  out_coeff,
	output logic                               out_odd,
	output logic                               out_last,
	output logic                               out_short
);
	import dwt97_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int KW  = $clog2(MAX_LINE);
	localparam int CW  = KW + 3;
	localparam int OPW = SB + 1;
	localparam int PW  = OPW + COEF_W;
	localparam int SHW = PW - FRAC;
	localparam int RW  = SHW + 1;
	localparam int IW  = (SB > IO_W) ? SB : IO_W;

	localparam logic signed [IW-1:0] IN_MAX  = {{(IW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
	localparam logic signed [IW-1:0] IN_MIN  = ~IN_MAX;
	localparam logic signed [IW-1:0] OUT_MAX = {{(IW - IO_W + 1){1'b0}}, {(IO_W - 1){1'b1}}};
	localparam logic signed [IW-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic signed [RW-1:0] RES_MAX = {{(RW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
	localparam logic signed [RW-1:0] RES_MIN = ~RES_MAX;

	logic signed [SB-1:0]  win_q [WIN_DEPTH];
	logic signed [IW-1:0]  in_ext;
	logic signed [SB-1:0]  in_sat;

	logic signed [CW-1:0]  ki, ji, ti, di;
	logic [WIN_IDX_W-1:0]  win_idx;

	logic [SB-1:0]         rd_a_raw, rd_b_raw;
	logic signed [SB-1:0]  rd_a, rd_b;
	logic signed [OPW-1:0] op;
	logic signed [PW-1:0]  prod_s1;
	logic signed [SHW-1:0] sh;
	logic signed [RW-1:0]  base, res;
	logic signed [SB-1:0]  res_sat;
	logic signed [IW-1:0]  mid_ext;
	logic signed [IO_W-1:0] mid_sat;

	logic                  ram_we;
	logic [SB-1:0]         ram_wdata;

	logic                  ov_q;
	logic signed [IO_W-1:0] coeff_q;
	logic                  odd_q, last_q, short_q;

	// input saturation to the working width
	always_comb begin
		in_ext = IW'(in_sample);
		if (in_ext > IN_MAX) begin
			in_sat = IN_MAX[SB-1:0];
		end else if (in_ext < IN_MIN) begin
			in_sat = IN_MIN[SB-1:0];
		end else begin
			in_sat = in_ext[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WIN_DEPTH; w++) begin
				win_q[w] <= '0;
			end
		end else if (cmd.win_clear) begin
			for (int w = 0; w < WIN_DEPTH; w++) begin
				win_q[w] <= '0;
			end
		end else if (cmd.win_shift) begin
			win_q[0] <= in_sat;
			for (int w = 1; w < WIN_DEPTH; w++) begin
				win_q[w] <= win_q[w-1];
			end
		end
	end

	// position of tap wt around result k, mirrored at the line start and, once the line has ended, at its end
	always_comb begin
		ki = signed'(CW'(k));
		ji = signed'(CW'(j));
		ti = ki + signed'(CW'(cmd.wt)) - signed'(CW'(EXTEND));
		if (ti < 0) begin
			ti = -ti;
		end
		if (cmd.ended && ti > ji) begin
			ti = (ji <<< 1) - ti;
		end
		if (ti < 0) begin
			ti = '0;
		end
		if (ti > ji) begin
			ti = ji;
		end
		di = ji - ti;
		if (di > signed'(CW'(WIN_DEPTH - 1))) begin
			di = signed'(CW'(WIN_DEPTH - 1));
		end
		win_idx = di[WIN_IDX_W-1:0];
	end

	dwt97_ram #(
		.WIDTH (SB),
		.DEPTH (TAPS)
	) u_partials (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cmd.wt),
		.wdata   (ram_wdata),
		.raddr_a (cmd.ra),
		.raddr_b (cmd.rb),
		.rdata_a (rd_a_raw),
		.rdata_b (rd_b_raw)
	);

	assign rd_a = signed'(rd_a_raw);
	assign rd_b = signed'(rd_b_raw);

	assign op = cmd.lift_op ? (OPW'(rd_a) + OPW'(rd_b)) : OPW'(rd_a);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= op * cmd.coef;
		end
	end

	// round to nearest: +2^15 then floor shift, done as the floor shift plus the bit below the binary point
	always_comb begin
		sh   = prod_s1[PW-1:FRAC] + SHW'(prod_s1[FRAC-1]);
		base = cmd.lift_op ? RW'(rd_a) : '0;
		res  = cmd.sub ? (base - RW'(sh)) : (base + RW'(sh));
		if (res > RES_MAX) begin
			res_sat = RES_MAX[SB-1:0];
		end else if (res < RES_MIN) begin
			res_sat = RES_MIN[SB-1:0];
		end else begin
			res_sat = res[SB-1:0];
		end
	end

	assign ram_we    = cmd.load | cmd.wb;
	assign ram_wdata = cmd.load ? win_q[win_idx] : res_sat;

	always_comb begin
		mid_ext = IW'(rd_a);
		if (mid_ext > OUT_MAX) begin
			mid_sat = OUT_MAX[IO_W-1:0];
		end else if (mid_ext < OUT_MIN) begin
			mid_sat = OUT_MIN[IO_W-1:0];
		end else begin
			mid_sat = mid_ext[IO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			coeff_q <= cmd.err ? '0 : mid_sat;
			odd_q   <= cmd.odd;
			last_q  <= cmd.last;
			short_q <= cmd.err;
		end
	end

	assign status.out_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_coeff = coeff_q;
	assign out_odd   = odd_q;
	assign out_last  = last_q;
	assign out_short = short_q;

endmodule

FILE: design/dwt97_ctrl.sv
// Controller: line bookkeeping, direction register and the sequencer that
// walks fetch, scaling, the four lifting steps and result emission.
// Depends on dwt97_pkg.
`timescale 1ns / 1ps

module dwt97_ctrl #(
	parameter int MAX_LINE = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_line_end,
	output logic                        in_ready,
	input  logic                        cfg_we,
	input  logic                        cfg_direction,
	input  dwt97_pkg::dp_status_t       status,
	output dwt97_pkg::dp_cmd_t          cmd,
	output logic [$clog2(MAX_LINE)-1:0] k,
	output logic [$clog2(MAX_LINE)-1:0] j
);
	import dwt97_pkg::*;

	localparam int KW = $clog2(MAX_LINE);

	ctrl_state_t      state_q, state_n;
	logic [1:0]       ph_q, ph_n;
	logic [TAP_W-1:0] t_q, t_n;
	logic [1:0]       s_q, s_n;
	logic [KW-1:0]    k_q, k_n, j_q, j_n, count_q, count_n;
	logic             ended_q, ended_n, dir_q;
	logic             ended_now, tap_par, step_par, step_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_READ;
			t_q     <= '0;
			s_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			count_q <= '0;
			ended_q <= 1'b0;
			dir_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			ph_q    <= ph_n;
			t_q     <= t_n;
			s_q     <= s_n;
			k_q     <= k_n;
			j_q     <= j_n;
			count_q <= count_n;
			ended_q <= ended_n;
			if (cfg_we) begin
				dir_q <= cfg_direction;
			end
		end
	end

	assign tap_par   = k_q[0] ^ t_q[0];
	assign step_par  = dir_q ? s_q[0] : ~s_q[0];
	assign step_done = (t_q == TAP_W'(LIFT_HI) - TAP_W'(s_q));
	assign ended_now = in_line_end || (count_q == KW'(MAX_LINE - 1));

	always_comb begin
		state_n  = state_q;
		ph_n     = ph_q;
		t_n      = t_q;
		s_n      = s_q;
		k_n      = k_q;
		j_n      = j_q;
		count_n  = count_q;
		ended_n  = ended_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.ended = ended_q;
		cmd.wt    = t_q;
		cmd.ra    = t_q;
		cmd.rb    = t_q;
		cmd.sub   = dir_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.win_shift = 1'b1;
					j_n     = count_q;
					ended_n = ended_now;
					t_n     = '0;
					ph_n    = PH_READ;
					k_n     = count_q - KW'(EXTEND);
					if (ended_now) begin
						count_n = '0;
						state_n = (count_q < KW'(EXTEND)) ? ST_SHORT : ST_LOAD;
					end else begin
						count_n = count_q + KW'(1);
						if (count_q >= KW'(EXTEND)) begin
							state_n = ST_LOAD;
						end
					end
				end
			end

			ST_LOAD: begin
				cmd.load = 1'b1;
				if (t_q == LAST_TAP) begin
					ph_n = PH_READ;
					if (dir_q) begin
						state_n = ST_ISCALE;
						t_n     = '0;
					end else begin
						state_n = ST_LIFT;
						s_n     = '0;
						t_n     = TAP_W'(1);
					end
				end else begin
					t_n = t_q + TAP_W'(1);
				end
			end

			ST_ISCALE: begin
				// odd taps are high band: scale by 1/K, even by K
				cmd.coef = tap_par ? SCALE_INV_K : SCALE_K;
				case (ph_q)
					PH_READ: ph_n = PH_MUL;
					PH_MUL: begin
						cmd.mul = 1'b1;
						ph_n    = PH_WB;
					end
					default: begin
						cmd.wb = 1'b1;
						cmd.sub = 1'b0;
						ph_n   = PH_READ;
						if (t_q == LAST_TAP) begin
							state_n = ST_LIFT;
							s_n     = '0;
							t_n     = TAP_W'(1);
						end else begin
							t_n = t_q + TAP_W'(1);
						end
					end
				endcase
			end

			ST_LIFT: begin
				cmd.lift_op = 1'b1;
				cmd.coef    = lift_coef(dir_q, s_q);
				cmd.ra      = (ph_q == PH_READ) ? (t_q - TAP_W'(1)) : t_q;
				cmd.rb      = t_q + TAP_W'(1);
				if (tap_par == step_par) begin
					case (ph_q)
						PH_READ: ph_n = PH_MUL;
						PH_MUL: begin
							cmd.mul = 1'b1;
							ph_n    = PH_WB;
						end
						default: begin
							cmd.wb = 1'b1;
							ph_n   = PH_READ;
						end
					endcase
				end
				if (tap_par != step_par || ph_q == PH_WB) begin
					if (step_done) begin
						if (s_q == 2'd3) begin
							state_n = dir_q ? ST_EMIT : ST_FSCALE;
						end else begin
							s_n = s_q + 2'd1;
							t_n = TAP_W'(s_q) + TAP_W'(2);
						end
					end else begin
						t_n = t_q + TAP_W'(1);
					end
				end
			end

			ST_FSCALE: begin
				cmd.coef = k_q[0] ? SCALE_K : SCALE_INV_K;
				cmd.ra   = MID_TAP;
				cmd.wt   = MID_TAP;
				cmd.sub  = 1'b0;
				case (ph_q)
					PH_READ: ph_n = PH_MUL;
					PH_MUL: begin
						cmd.mul = 1'b1;
						ph_n    = PH_WB;
					end
					default: begin
						cmd.wb  = 1'b1;
						ph_n    = PH_READ;
						state_n = ST_EMIT;
					end
				endcase
			end

			ST_EMIT: begin
				cmd.ra   = MID_TAP;
				cmd.odd  = k_q[0];
				cmd.last = ended_q && (k_q == j_q);
				if (ph_q == PH_READ) begin
					ph_n = PH_MUL;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					ph_n     = PH_READ;
					t_n      = '0;
					if (!ended_q) begin
						state_n = ST_IDLE;
					end else if (k_q == j_q) begin
						state_n = ST_CLEAR;
					end else begin
						k_n     = k_q + KW'(1);
						state_n = ST_LOAD;
					end
				end
			end

			ST_SHORT: begin
				cmd.last = 1'b1;
				cmd.err  = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_CLEAR;
				end
			end

			ST_CLEAR: begin
				cmd.win_clear = 1'b1;
				ended_n       = 1'b0;
				state_n       = ST_IDLE;
			end

			default: state_n = ST_IDLE;
		endcase
	end

	assign k = k_q;
	assign j = j_q;

endmodule

FILE: design/dwt97_lifting_line_filter.sv
// Top level of the 9/7 lifting line filter: controller, datapath and checks.
// Depends on dwt97_pkg, dwt97_if, dwt97_ctrl, dwt97_datapath and the macros header.
//
// One line of Q15.8 samples enters one item at a time; the last item carries
// line_end (forced at MAX_LINE samples). The filter runs the irreversible 9/7
// lifting transform, forward or inverse per the direction register, with
// whole-sample symmetric extension at both ends, and emits interleaved
// coefficients four samples behind the input; the last item flushes the final
// five. Lines under five samples give one result with too_short set. Every
// result is built by one shared multiplier over a nine-entry partials RAM:
// the nine taps are fetched, then each lifting or scaling multiply goes through
// read, multiply and write-back phases while a skipped tap is stepped over, and
// the result is then handed off, waiting out any receiver stall. An item is
// accepted and then takes that work once, five times at line end followed by a
// window clear, or nothing more when it yields no result. A short line is
// accepted, gives one result and then the clear.
`timescale 1ns / 1ps
`include "dwt97_lifting_line_filter_macros.svh"

module dwt97_lifting_line_filter #(
	parameter int MAX_LINE    = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	dwt97_sample_if.sink    samples,
	dwt97_result_if.source  results,
	dwt97_cfg_if.sink       cfg
);
	import dwt97_pkg::*;

	localparam int KW = $clog2(MAX_LINE);

	dp_cmd_t       cmd;
	dp_status_t    status;
	logic [KW-1:0] k, j;
	logic          in_ready;

	assign cfg.ready     = 1'b1;
	assign samples.ready = in_ready;

	dwt97_ctrl #(
		.MAX_LINE (MAX_LINE)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (samples.valid),
		.in_line_end   (samples.line_end),
		.in_ready      (in_ready),
		.cfg_we        (cfg.valid & cfg.ready),
		.cfg_direction (cfg.direction),
		.status        (status),
		.cmd           (cmd),
		.k             (k),
		.j             (j)
	);

	dwt97_datapath #(
		.MAX_LINE    (MAX_LINE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.k         (k),
		.j         (j),
		.in_sample (samples.sample),
		.status    (status),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_coeff (results.coeff),
		.out_odd   (results.odd_position),
		.out_last  (results.run_last),
		.out_short (results.too_short)
	);

	// no new item while taps are being loaded
	`DWT97_ASSERT_SAME(a_load_blocks_input, clk, arst_n, cmd.load, !samples.ready, "item taken during tap load")
	// a held result is never overwritten
	`DWT97_ASSERT_SAME(a_emit_needs_room, clk, arst_n, cmd.emit, results.ready || !results.valid, "result overwritten")
	// a line end always starts a flush or a short-line result
	`DWT97_ASSERT_NEXT(a_line_end_busy, clk, arst_n, samples.valid && samples.ready && samples.line_end, !samples.ready, "line end not flushed")

endmodule

FILE: tb/dwt97_lifting_line_filter_tb.sv
// Testbench of the 9/7 lifting line filter: directed and random lines, both directions.
// Depends on dwt97_pkg, dwt97_if and the dwt97_lifting_line_filter RTL.
// A built-in predictor works out each result and a checker compares every output item.
`timescale 1ns / 1ps

module dwt97_lifting_line_filter_tb;
	import dwt97_pkg::*;

	localparam int MAX_LINE   = 4096;
	localparam int WIN_N      = 12;
	localparam int N_TAPS     = 9;
	localparam int HALF       = 4;
	localparam int SETTLE     = 500;
	localparam int STALL_MAX  = 40000;
	localparam int EXP_DEPTH  = 64;
	localparam bit DIR_FWD    = 1'b0;
	localparam bit DIR_INV    = 1'b1;

	typedef struct {
		logic [IO_W-1:0] coeff;
		bit              odd;
		bit              last;
		bit              err;
	} dwt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dwt97_sample_if samples();
	dwt97_result_if results();
	dwt97_cfg_if    cfg();

	dwt97_lifting_line_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	always #5 clk = ~clk;

	// predictor state
	longint      line_win [WIN_N];
	int          line_count;
	bit          dir_now;

	// expected results, ring of EXP_DEPTH entries
	dwt_result_t exp_store [EXP_DEPTH];
	int          exp_head;
	int          exp_tail;

	int errors;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	function automatic int exp_pending();
		return exp_tail - exp_head;
	endfunction

	function automatic void exp_put(dwt_result_t r);
		exp_store[exp_tail % EXP_DEPTH] = r;
		exp_tail++;
	endfunction

	function automatic longint sat_to(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// round to nearest, floor after shift
	function automatic longint mul_q16(longint c, longint v);
		return (c * v + 32768) >>> 16;
	endfunction

	function automatic longint win_tap(longint i, longint newest, longint len, bit ended);
		longint d;
		if (i < 0) i = -i;
		if (ended && i > len - 1) i = 2 * (len - 1) - i;
		if (i < 0) i = 0;
		if (i > newest) i = newest;
		d = newest - i;
		if (d > WIN_N - 1) d = WIN_N - 1;
		return line_win[d];
	endfunction

	function automatic longint lift_at(longint k, longint newest, longint len, bit ended);
		longint part [N_TAPS];
		longint c, acc, d;
		bit par;
		for (int t = 0; t < N_TAPS; t++)
			part[t] = win_tap(k + t - HALF, newest, len, ended);
		if (dir_now) begin
			for (int t = 0; t < N_TAPS; t++) begin
				c = ((k + t) & 1) ? longint'(SCALE_INV_K) : longint'(SCALE_K);
				part[t] = sat_to(mul_q16(c, part[t]), 24);
			end
		end
		for (int s = 0; s < 4; s++) begin
			par = dir_now ? s[0] : ~s[0];
			for (int t = s + 1; t <= N_TAPS - 2 - s; t++) begin
				if (((k + t) & 1) != par) continue;
				acc = part[t-1] + part[t+1];
				case (s)
					0: c = dir_now ? longint'(LIFT_DELTA) : longint'(LIFT_ALPHA);
					1: c = dir_now ? longint'(LIFT_GAMMA) : longint'(LIFT_BETA);
					2: c = dir_now ? longint'(LIFT_BETA)  : longint'(LIFT_GAMMA);
					default: c = dir_now ? longint'(LIFT_ALPHA) : longint'(LIFT_DELTA);
				endcase
				d = mul_q16(c, acc);
				part[t] = sat_to(dir_now ? part[t] - d : part[t] + d, 24);
			end
		end
		if (!dir_now) begin
			c = (k & 1) ? longint'(SCALE_K) : longint'(SCALE_INV_K);
			part[HALF] = sat_to(mul_q16(c, part[HALF]), 24);
		end
		return sat_to(part[HALF], IO_W);
	endfunction

	function automatic void push_coeff(longint v, bit odd, bit last, bit err);
		dwt_result_t r;
		r.coeff = v[IO_W-1:0];
		r.odd   = odd;
		r.last  = last;
		r.err   = err;
		exp_put(r);
	endfunction

	function automatic void predict_sample(logic [IO_W-1:0] smp, bit lend);
		longint j;
		bit ended;
		j = line_count;
		for (int i = WIN_N - 1; i > 0; i--) line_win[i] = line_win[i-1];
		line_win[0] = longint'(signed'(smp));
		ended = lend || (j + 1 >= MAX_LINE);
		if (!ended) begin
			line_count = int'(j + 1);
			if (j >= HALF)
				push_coeff(lift_at(j - HALF, j, 0, 1'b0), bit'((j - HALF) & 1), 1'b0, 1'b0);
			return;
		end
		if (j + 1 < 5) begin
			push_coeff(0, 1'b0, 1'b1, 1'b1);
		end else begin
			for (longint k = j - HALF; k <= j; k++)
				push_coeff(lift_at(k, j, j + 1, 1'b1), bit'(k & 1), k == j, 1'b0);
		end
		foreach (line_win[i]) line_win[i] = 0;
		line_count = 0;
	endfunction

	// valid stays high after an accept so items can follow back to back
	task automatic send_sample(logic [IO_W-1:0] smp, bit lend);
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid    <= 1'b1;
		samples.sample   <= smp;
		samples.line_end <= lend;
		do @(posedge clk); while (!samples.ready);
		predict_sample(smp, lend);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (exp_pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_direction(bit v);
		drain();
		cfg.valid     <= 1'b1;
		cfg.direction <= v;
		do @(posedge clk); while (!cfg.ready);
		dir_now = v;
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [IO_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return IO_W'($urandom_range(4095));
			default: return IO_W'($urandom);
		endcase
	endfunction

	task automatic send_line(int len);
		for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
	endtask

	task automatic test_short_lines();
		for (int len = 1; len <= 4; len++) send_line(len);
		send_line(5);
	endtask

	task automatic test_extremes();
		for (int d = 0; d < 2; d++) begin
			write_direction(d ? DIR_INV : DIR_FWD);
			for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000, i == 7);
			for (int i = 0; i < 6; i++) send_sample(24'h7FFFFF, i == 5);
			send_sample(24'h000000, 1'b1);
		end
	endtask

	// new direction takes effect between two samples of one line
	task automatic test_direction_mid_line();
		write_direction(DIR_FWD);
		for (int i = 0; i < 7; i++) send_sample(rand_sample(), 1'b0);
		write_direction(DIR_INV);
		for (int i = 0; i < 5; i++) send_sample(rand_sample(), i == 4);
	endtask

	task automatic test_random_phase(int idle, int stall, int items);
		int sent;
		int len;
		write_direction(bit'($urandom_range(1)));
		idle_pct  = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(9))
				0: len = int'($urandom_range(1, 4));
				1: len = int'($urandom_range(17, 40));
				default: len = int'($urandom_range(5, 16));
			endcase
			send_line(len);
			sent += len;
			if (sent > items / 2 && sent - len <= items / 2) drain();
		end
	endtask

	// result receiver and checker
	always @(posedge clk) begin
		dwt_result_t exp_r;
		if (results.valid && results.ready) begin
			if (exp_pending() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result item coeff=%h", results.coeff);
			end else begin
				exp_r = exp_store[exp_head % EXP_DEPTH];
				exp_head++;
				if (results.coeff !== exp_r.coeff || results.odd_position !== exp_r.odd ||
						results.run_last !== exp_r.last || results.too_short !== exp_r.err) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp coeff=%h odd=%b last=%b short=%b, got %h %b %b %b",
							exp_r.coeff, exp_r.odd, exp_r.last, exp_r.err, results.coeff,
							results.odd_position, results.run_last, results.too_short);
				end
			end
		end
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready) ||
				(cfg.valid && cfg.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("dwt97_lifting_line_filter regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		exp_head = 0;
		exp_tail = 0;
		dir_now = DIR_FWD;
		line_count = 0;
		foreach (line_win[i]) line_win[i] = 0;
		samples.valid    = 1'b0;
		samples.sample   = '0;
		samples.line_end = 1'b0;
		cfg.valid        = 1'b0;
		cfg.direction    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_lines();
		test_extremes();
		test_direction_mid_line();
		test_random_phase(0, 0, 90);
		test_random_phase(81, 0, 90);
		test_random_phase(0, 81, 90);
		test_random_phase(35, 35, 90);
		drain();

		if (errors == 0 && exp_pending() == 0) begin
			$display("dwt97_lifting_line_filter regression: pass");
		end else begin
			$display("dwt97_lifting_line_filter regression: fail");
		end
		$finish;
	end

endmodule
